@@ rtl/sfr_pkg.sv @@
// shared types and constants for the stream find-and-replace block
package sfr_pkg;

    localparam int ADDR_WIDTH = 6;
    localparam int DATA_WIDTH = 64;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [2:0] REG_NEEDLE_CHARS  = 3'd0;
    localparam logic [2:0] REG_NEEDLE_LENGTH = 3'd1;
    localparam logic [2:0] REG_REPL_CHARS    = 3'd2;
    localparam logic [2:0] REG_REPL_LENGTH   = 3'd3;
    localparam logic [2:0] REG_IGNORE_CASE   = 3'd4;

    typedef struct packed {
        logic [15:0] text_char;
        logic        end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_char;
        logic        char_valid;
        logic        last_of_text;
        logic [15:0] match_count;
    } out_item_t;

    typedef struct packed {
        logic [63:0] needle_chars;
        logic [2:0]  needle_length;
        logic [63:0] repl_chars;
        logic [2:0]  repl_length;
        logic        ignore_case;
    } cfg_t;

    // control part of one emit command handed from front to back
    typedef struct packed {
        logic        use_repl;
        logic        end_mark;
        logic        bare;
        logic [15:0] match_count;
    } cmd_ctrl_t;

endpackage

@@ rtl/stream_find_replace.sv @@
// top level of the streaming find-and-replace block with its register port
//
// text channel (text_valid/text_ready/text_item) takes one character or an
// end marker per transaction; result channel (result_valid/result_ready/
// result_item) gives the rewritten text, one character or bare end marker per transaction.
// registers sit on the apb port at byte address 8*i: needle_chars,
// needle_length, repl_chars, repl_length, ignore_case; write them only while
// the block is idle.
// the front end compares the pending window against the needle and hands an
// emit command to a two-entry queue in the same cycle it takes a transaction;
// the back end walks each command one result per cycle, barring output stalls, into an output reg.
// the first result passes through a queue entry and then the output register.
// throughput: one text transaction per cycle while each gives at most one
// result; an item giving k results holds the back end until all k are given (match
// bursts, end-of-text flushes), and text_ready drops once the queue is full.
// a result_ready stall holds the output register and backs up into the queue.
// reset clears window, count, queue, output valid and all config registers.
module stream_find_replace #(
    parameter int NEEDLE_MAX = 4,
    parameter int REPL_MAX = 4,
    parameter int CHAR_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // text channel
    input  logic                                text_valid,
    output logic                                text_ready,
    input  sfr_pkg::in_item_t                   text_item,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output sfr_pkg::out_item_t                  result_item,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfr_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [sfr_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [sfr_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready
);

    localparam int MAXR = (NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX;
    localparam int CNTW = $clog2(MAXR + 1);
    localparam int CMD_WIDTH = $bits(sfr_pkg::cmd_ctrl_t) + CNTW + MAXR * CHAR_WIDTH;

    sfr_pkg::cfg_t cfg_reg, cfg_next;
    logic [2:0]    reg_sel;
    logic          cfg_write;

    logic                              text_accept;
    logic                              q_full;
    logic                              f_push;
    sfr_pkg::cmd_ctrl_t                f_ctrl;
    logic [CNTW-1:0]                   f_count;
    logic [MAXR-1:0][CHAR_WIDTH-1:0]   f_chars;
    logic                              q_valid;
    logic                              q_pop;
    logic [CMD_WIDTH-1:0]              q_data;
    sfr_pkg::cmd_ctrl_t                q_ctrl;
    logic [CNTW-1:0]                   q_count;
    logic [MAXR-1:0][CHAR_WIDTH-1:0]   q_chars;

    // register port: zero wait states, write in the access phase
    assign pready = 1'b1;
    assign reg_sel = paddr[5:3];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                sfr_pkg::REG_NEEDLE_CHARS:  cfg_next.needle_chars = pwdata;
                sfr_pkg::REG_NEEDLE_LENGTH: cfg_next.needle_length = pwdata[2:0];
                sfr_pkg::REG_REPL_CHARS:    cfg_next.repl_chars = pwdata;
                sfr_pkg::REG_REPL_LENGTH:   cfg_next.repl_length = pwdata[2:0];
                sfr_pkg::REG_IGNORE_CASE:   cfg_next.ignore_case = pwdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            sfr_pkg::REG_NEEDLE_CHARS:  prdata = cfg_reg.needle_chars;
            sfr_pkg::REG_NEEDLE_LENGTH: prdata = 64'(cfg_reg.needle_length);
            sfr_pkg::REG_REPL_CHARS:    prdata = cfg_reg.repl_chars;
            sfr_pkg::REG_REPL_LENGTH:   prdata = 64'(cfg_reg.repl_length);
            sfr_pkg::REG_IGNORE_CASE:   prdata = 64'(cfg_reg.ignore_case);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end takes a transaction whenever the queue has room
    assign text_ready = !q_full;
    assign text_accept = text_valid && text_ready;

    sfr_front #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .REPL_MAX   (REPL_MAX),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (text_item),
        .accept     (text_accept),
        .push       (f_push),
        .push_ctrl  (f_ctrl),
        .push_count (f_count),
        .push_chars (f_chars)
    );

    sfr_queue #(
        .WIDTH (CMD_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data ({f_ctrl, f_count, f_chars}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign {q_ctrl, q_count, q_chars} = q_data;

    sfr_back #(
        .NEEDLE_MAX (NEEDLE_MAX),
        .REPL_MAX   (REPL_MAX),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .repl_chars   (cfg_reg.repl_chars),
        .cmd_valid    (q_valid),
        .cmd_ctrl     (q_ctrl),
        .cmd_count    (q_count),
        .cmd_chars    (q_chars),
        .cmd_pop      (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

endmodule

@@ rtl/sfr_front.sv @@
// front end: window state, needle compare and emit command build
module sfr_front #(
    parameter int NEEDLE_MAX = 4,
    parameter int REPL_MAX = 4,
    parameter int CHAR_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sfr_pkg::cfg_t                         cfg,
    input  sfr_pkg::in_item_t                     item,
    input  logic                                  accept,
    output logic                                  push,
    output sfr_pkg::cmd_ctrl_t                    push_ctrl,
    output logic [$clog2(((NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX) + 1)-1:0] push_count,
    output logic [((NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX)-1:0][CHAR_WIDTH-1:0] push_chars
);

    localparam int CW = CHAR_WIDTH;
    localparam int WIN = NEEDLE_MAX;
    localparam int MAXR = (NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX;
    localparam int CNTW = $clog2(MAXR + 1);
    localparam int FW = $clog2(WIN + 1);
    localparam int LW = $clog2(NEEDLE_MAX + 1);
    localparam int RLW = $clog2(REPL_MAX + 1);
    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    logic [WIN-1:0][CW-1:0] win_reg, win_next;
    logic [FW-1:0]          fill_reg, fill_next;
    logic [15:0]            total_reg, total_next;

    logic [WIN-1:0][CW-1:0]  needle;
    logic [WIN-1:0][CW-1:0]  buf_chars;
    logic [WIN-1:0][WIN-1:0] eq;
    logic [WIN:0]            ok;
    logic [LW-1:0]           nlen;
    logic [RLW-1:0]          rlen;
    logic [FW-1:0]           n;
    logic [FW-1:0]           head;
    logic                    full_match;
    logic [CW-1:0]           new_char;

    function automatic logic [CW-1:0] fold_char(input logic [CW-1:0] c, input logic en);
        logic [CW-1:0] r;
        r = c;
        if (en && c >= CW'(UPPER_A) && c <= CW'(UPPER_Z))
        begin
            r = c + CW'(CASE_GAP);
        end
        return r;
    endfunction

    assign new_char = CW'(item.text_char);
    assign n = fill_reg + FW'(1);

    // effective lengths, clamped to the configured maxima
    assign nlen = (int'(cfg.needle_length) > NEEDLE_MAX) ? LW'(NEEDLE_MAX)
                                                          : LW'(cfg.needle_length);
    assign rlen = (int'(cfg.repl_length) > REPL_MAX) ? RLW'(REPL_MAX)
                                                      : RLW'(cfg.repl_length);

    // window plus new character, compare every offset against the needle
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            if (i * CW < 64)
            begin
                needle[i] = CW'(cfg.needle_chars >> (i * CW));
            end
            else
            begin
                needle[i] = '0;
            end
            if (i < int'(fill_reg))
            begin
                buf_chars[i] = win_reg[i];
            end
            else if (i == int'(fill_reg))
            begin
                buf_chars[i] = new_char;
            end
            else
            begin
                buf_chars[i] = '0;
            end
        end
        for (int h = 0; h < WIN; h++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if (h + j < WIN)
                begin
                    eq[h][j] = fold_char(buf_chars[h + j], cfg.ignore_case)
                            == fold_char(needle[j], cfg.ignore_case);
                end
                else
                begin
                    eq[h][j] = 1'b0;
                end
            end
        end
    end

    // ok[h]: the tail starting at h is empty or a proper needle prefix
    always_comb
    begin
        int  m;
        logic run;
        for (int h = 0; h <= WIN; h++)
        begin
            m = int'(n) - h;
            run = 1'b1;
            if (h < WIN)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    if (j < m && !eq[h][j])
                    begin
                        run = 1'b0;
                    end
                end
            end
            if (m == 0)
            begin
                ok[h] = 1'b1;
            end
            else if (m < 0)
            begin
                ok[h] = 1'b0;
            end
            else
            begin
                ok[h] = (m < int'(nlen)) && run;
            end
        end
        head = FW'(WIN);
        for (int h = WIN; h >= 0; h--)
        begin
            if (ok[h])
            begin
                head = FW'(h);
            end
        end
    end

    always_comb
    begin
        logic run0;
        run0 = 1'b1;
        for (int j = 0; j < WIN; j++)
        begin
            if (j < int'(n) && !eq[0][j])
            begin
                run0 = 1'b0;
            end
        end
        full_match = (nlen != '0) && (int'(n) == int'(nlen)) && run0;
    end

    always_comb
    begin
        push = 1'b0;
        push_ctrl = '0;
        push_count = '0;
        push_chars = '0;
        win_next = win_reg;
        fill_next = fill_reg;
        total_next = total_reg;
        if (accept)
        begin
            if (item.end_of_text)
            begin
                // flush the window, or a bare marker when it is empty
                for (int i = 0; i < WIN; i++)
                begin
                    push_chars[i] = win_reg[i];
                end
                push_ctrl.bare = (fill_reg == '0);
                push_ctrl.end_mark = 1'b1;
                push_ctrl.match_count = total_reg;
                push_count = (fill_reg == '0) ? CNTW'(1) : CNTW'(fill_reg);
                push = 1'b1;
                win_next = '0;
                fill_next = '0;
                total_next = '0;
            end
            else if (full_match)
            begin
                total_next = (total_reg == sfr_pkg::COUNT_MAX) ? total_reg
                                                               : total_reg + 16'd1;
                push_ctrl.use_repl = 1'b1;
                push_ctrl.match_count = total_next;
                push_count = CNTW'(rlen);
                push = (rlen != '0);
                win_next = '0;
                fill_next = '0;
            end
            else
            begin
                // emit leading characters up to the first viable start
                for (int i = 0; i < WIN; i++)
                begin
                    if (i < int'(head))
                    begin
                        push_chars[i] = buf_chars[i];
                    end
                end
                push_ctrl.match_count = total_reg;
                push_count = CNTW'(head);
                push = (head != '0);
                win_next = '0;
                for (int i = 0; i < WIN; i++)
                begin
                    for (int k = 0; k <= WIN; k++)
                    begin
                        if (k == int'(head) && i + k < WIN)
                        begin
                            win_next[i] = buf_chars[i + k];
                        end
                    end
                end
                fill_next = n - head;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            fill_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
            fill_reg <= fill_next;
            total_reg <= total_next;
        end
    end

endmodule

@@ rtl/sfr_queue.sv @@
// two-entry command queue between front and back
module sfr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 2;

    logic [DEPTH-1:0][WIDTH-1:0] entry_reg;
    logic                        wr_ptr_reg, wr_ptr_next;
    logic                        rd_ptr_reg, rd_ptr_next;
    logic [1:0]                  count_reg, count_next;
    logic                        do_pop;

    assign full = (count_reg == 2'(DEPTH));
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_pop = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/sfr_back.sv @@
// back end: walks each command and drives the result output register
module sfr_back #(
    parameter int NEEDLE_MAX = 4,
    parameter int REPL_MAX = 4,
    parameter int CHAR_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [63:0]                           repl_chars,
    input  logic                                  cmd_valid,
    input  sfr_pkg::cmd_ctrl_t                    cmd_ctrl,
    input  logic [$clog2(((NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX) + 1)-1:0] cmd_count,
    input  logic [((NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX)-1:0][CHAR_WIDTH-1:0] cmd_chars,
    output logic                                  cmd_pop,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output sfr_pkg::out_item_t                    result_item
);

    localparam int CW = CHAR_WIDTH;
    localparam int MAXR = (NEEDLE_MAX > REPL_MAX) ? NEEDLE_MAX : REPL_MAX;
    localparam int CNTW = $clog2(MAXR + 1);
    localparam int IW = (MAXR > 1) ? $clog2(MAXR) : 1;

    logic [MAXR-1:0][CW-1:0] rch;
    logic [IW-1:0]           idx_reg, idx_next;
    logic                    out_valid_reg, out_valid_next;
    sfr_pkg::out_item_t      out_item_reg, out_item_next;
    logic                    load;
    logic                    last_idx;
    logic [CW-1:0]           ch;

    always_comb
    begin
        for (int i = 0; i < MAXR; i++)
        begin
            if (i < REPL_MAX && i * CW < 64)
            begin
                rch[i] = CW'(repl_chars >> (i * CW));
            end
            else
            begin
                rch[i] = '0;
            end
        end
    end

    assign load = cmd_valid && (!out_valid_reg || result_ready);
    assign last_idx = (idx_reg == IW'(cmd_count - CNTW'(1)));
    assign cmd_pop = load && last_idx;
    assign ch = cmd_ctrl.use_repl ? rch[idx_reg] : cmd_chars[idx_reg];

    always_comb
    begin
        idx_next = idx_reg;
        out_item_next = out_item_reg;
        out_valid_next = out_valid_reg && !result_ready;
        if (load)
        begin
            idx_next = last_idx ? '0 : idx_reg + IW'(1);
            out_valid_next = 1'b1;
            out_item_next.out_char = cmd_ctrl.bare ? 16'd0 : 16'(ch);
            out_item_next.char_valid = !cmd_ctrl.bare;
            out_item_next.last_of_text = cmd_ctrl.end_mark && last_idx;
            out_item_next.match_count = cmd_ctrl.match_count;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item = out_item_reg;

endmodule
